>>> hw/rtl/connack_packet_parser_assert.svh
// Assertion macros shared by the CONNACK parser RTL.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef CONNACK_PACKET_PARSER_ASSERT_SVH
`define CONNACK_PACKET_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define CPP_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("connack parser assertion failed");
`define CPP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  `CPP_ASSERT(name, clk, rst_n, (ante) |-> (cons))
`define CPP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  `CPP_ASSERT(name, clk, rst_n, (ante) |=> (cons))
`else
`define CPP_ASSERT(name, clk, rst_n, prop)
`define CPP_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define CPP_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/cpp_pkg.sv
// Package for the CONNACK parser: widths, phase codes and shared types.
// No dependencies.
package cpp_pkg;

  localparam int CPP_COUNT_BITS = 32;
  localparam int LEN_W          = 28;
  localparam int CONS_W         = 29;
  localparam int IDX_W          = 3;

  localparam logic [3:0] CONNACK_TYPE = 4'h2;
  localparam logic [2:0] VINT_MAX_IDX = 3'd3;

  typedef enum logic [5:0] {
    PH_TYPE   = 6'b000001,
    PH_RLEN   = 6'b000010,
    PH_ACK    = 6'b000100,
    PH_REASON = 6'b001000,
    PH_PLEN   = 6'b010000,
    PH_DONE   = 6'b100000
  } cpp_phase_t;

  // One step of the variable byte integer decoder.
  typedef struct packed {
    logic [LEN_W-1:0] acc;
    logic [IDX_W-1:0] idx;
    logic             done;
    logic             err;
  } cpp_vint_t;

endpackage

>>> hw/rtl/cpp_ifs.sv
// Valid/ready channel interfaces for the CONNACK parser byte and result beats.
// Depends on cpp_pkg for field widths.
interface cpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cpp_out_if import cpp_pkg::*;;
  logic              valid;
  logic              ready;
  logic              ok;
  logic              session_present;
  logic [7:0]        reason_code;
  logic [CONS_W-1:0] consumed_length;

  modport source (output valid, output ok, output session_present,
                  output reason_code, output consumed_length, input ready);
  modport sink   (input valid, input ok, input session_present,
                  input reason_code, input consumed_length, output ready);
endinterface

>>> hw/rtl/connack_packet_parser.sv
// Top level of the CONNACK parser: phase machine, final snapshot and result register.
// Depends on cpp_pkg, cpp_ifs, cpp_varint and connack_packet_parser_assert.svh.
//
//   channel   dir  beat                                              
//   in_chan   in   data_byte, last_byte                              
//   out_chan  out  ok, session_present, reason_code, consumed_length 
//
// One byte per cycle while in_chan.ready is high. After its final byte is taken, a result passes
// through a snapshot stage, then the length checks into the result register.
// rst_n is synchronous; it clears the phase machine, counters and both valids.
// A stalled result holds the snapshot; in_chan.ready drops only when both
// stages are full and out_chan.ready is low.
`include "connack_packet_parser_assert.svh"

module connack_packet_parser import cpp_pkg::*; #(
  parameter int COUNT_BITS = CPP_COUNT_BITS
) (
  input logic       clk,
  input logic       rst_n,
  cpp_in_if.sink    in_chan,
  cpp_out_if.source out_chan
);

  // parser state
  cpp_phase_t            phase_r, phase_nxt;
  logic                  err_r, err_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0]      acc_r, acc_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [LEN_W-1:0]      rlen_r, rlen_nxt;
  logic [IDX_W-1:0]      reb_r, reb_nxt;
  logic [LEN_W-1:0]      plen_r, plen_nxt;
  logic [IDX_W-1:0]      peb_r, peb_nxt;
  logic                  sess_r, sess_nxt;
  logic [7:0]            reason_r, reason_nxt;

  // snapshot of the final beat
  logic                  fin_valid_r;
  logic                  fin_good_r;
  logic [COUNT_BITS-1:0] fin_total_r;
  logic [LEN_W-1:0]      fin_rlen_r;
  logic [IDX_W-1:0]      fin_reb_r;
  logic [LEN_W-1:0]      fin_plen_r;
  logic [IDX_W-1:0]      fin_peb_r;
  logic                  fin_sess_r;
  logic [7:0]            fin_reason_r;

  // result register
  logic                  out_valid_r;
  logic                  out_ok_r;
  logic                  out_sess_r;
  logic [7:0]            out_reason_r;
  logic [CONS_W-1:0]     out_cons_r;

  logic                  in_acc;
  logic                  fin_adv;
  cpp_vint_t             vstep;

  assign fin_adv        = !out_valid_r || out_chan.ready;
  assign in_chan.ready  = !fin_valid_r || fin_adv;
  assign in_acc         = in_chan.valid && in_chan.ready;

  cpp_varint u_varint (
    .acc  (acc_r),
    .idx  (idx_r),
    .data (in_chan.data_byte),
    .step (vstep)
  );

  always_comb begin
    phase_nxt  = phase_r;
    err_nxt    = err_r;
    cnt_nxt    = (cnt_r == '1) ? cnt_r : cnt_r + COUNT_BITS'(1);
    acc_nxt    = acc_r;
    idx_nxt    = idx_r;
    rlen_nxt   = rlen_r;
    reb_nxt    = reb_r;
    plen_nxt   = plen_r;
    peb_nxt    = peb_r;
    sess_nxt   = sess_r;
    reason_nxt = reason_r;
    if (!err_r) begin
      case (phase_r)
        PH_TYPE: begin
          if (in_chan.data_byte[7:4] != CONNACK_TYPE) err_nxt = 1'b1;
          else phase_nxt = PH_RLEN;
        end
        PH_RLEN: begin
          if (vstep.err) begin
            err_nxt = 1'b1;
          end else if (vstep.done) begin
            rlen_nxt  = vstep.acc;
            reb_nxt   = vstep.idx;
            acc_nxt   = '0;
            idx_nxt   = '0;
            phase_nxt = PH_ACK;
          end else begin
            acc_nxt = vstep.acc;
            idx_nxt = vstep.idx;
          end
        end
        PH_ACK: begin
          sess_nxt  = in_chan.data_byte[0];
          phase_nxt = PH_REASON;
        end
        PH_REASON: begin
          reason_nxt = in_chan.data_byte;
          phase_nxt  = PH_PLEN;
        end
        PH_PLEN: begin
          if (vstep.err) begin
            err_nxt = 1'b1;
          end else if (vstep.done) begin
            plen_nxt  = vstep.acc;
            peb_nxt   = vstep.idx;
            acc_nxt   = '0;
            idx_nxt   = '0;
            phase_nxt = PH_DONE;
          end else begin
            acc_nxt = vstep.acc;
            idx_nxt = vstep.idx;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TYPE;
      err_r    <= 1'b0;
      cnt_r    <= '0;
      acc_r    <= '0;
      idx_r    <= '0;
      rlen_r   <= '0;
      reb_r    <= '0;
      plen_r   <= '0;
      peb_r    <= '0;
      sess_r   <= 1'b0;
      reason_r <= '0;
    end else if (in_acc) begin
      if (in_chan.last_byte) begin
        // buffer ends: back to the type byte for the next one
        phase_r  <= PH_TYPE;
        err_r    <= 1'b0;
        cnt_r    <= '0;
        acc_r    <= '0;
        idx_r    <= '0;
        rlen_r   <= '0;
        reb_r    <= '0;
        plen_r   <= '0;
        peb_r    <= '0;
        sess_r   <= 1'b0;
        reason_r <= '0;
      end else begin
        phase_r  <= phase_nxt;
        err_r    <= err_nxt;
        cnt_r    <= cnt_nxt;
        acc_r    <= acc_nxt;
        idx_r    <= idx_nxt;
        rlen_r   <= rlen_nxt;
        reb_r    <= reb_nxt;
        plen_r   <= plen_nxt;
        peb_r    <= peb_nxt;
        sess_r   <= sess_nxt;
        reason_r <= reason_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (in_acc && in_chan.last_byte) begin
      fin_valid_r <= 1'b1;
    end else if (fin_adv) begin
      fin_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_chan.last_byte) begin
      fin_good_r   <= !err_nxt && (phase_nxt == PH_DONE);
      fin_total_r  <= cnt_nxt;
      fin_rlen_r   <= rlen_nxt;
      fin_reb_r    <= reb_nxt;
      fin_plen_r   <= plen_nxt;
      fin_peb_r    <= peb_nxt;
      fin_sess_r   <= sess_nxt;
      fin_reason_r <= reason_nxt;
    end
  end

  // length checks against the whole buffer
  logic [CONS_W-1:0] need_len;
  logic [CONS_W-1:0] cons_len;
  logic              chk_ok;

  always_comb begin
    need_len = CONS_W'(1) + CONS_W'(fin_reb_r) + CONS_W'(fin_rlen_r);
    cons_len = CONS_W'(3) + CONS_W'(fin_reb_r) + CONS_W'(fin_peb_r) + CONS_W'(fin_plen_r);
    chk_ok   = fin_good_r
               && (fin_total_r >= COUNT_BITS'(need_len))
               && (fin_total_r >= COUNT_BITS'(cons_len));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_adv) begin
      out_valid_r <= fin_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_adv && fin_valid_r) begin
      out_ok_r     <= chk_ok;
      out_sess_r   <= chk_ok && fin_sess_r;
      out_reason_r <= chk_ok ? fin_reason_r : 8'h00;
      out_cons_r   <= chk_ok ? cons_len : '0;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.ok              = out_ok_r;
  assign out_chan.session_present = out_sess_r;
  assign out_chan.reason_code     = out_reason_r;
  assign out_chan.consumed_length = out_cons_r;

  `CPP_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid_r && !out_ok_r, !out_sess_r && (out_reason_r == 8'h00) && (out_cons_r == '0))
  `CPP_ASSERT_IMP(a_ok_min_len, clk, rst_n, out_valid_r && out_ok_r, out_cons_r >= CONS_W'(5))
  `CPP_ASSERT_NXT(a_last_rearms, clk, rst_n, in_acc && in_chan.last_byte, (phase_r == PH_TYPE) && (cnt_r == '0) && fin_valid_r)
  `CPP_ASSERT_NXT(a_fin_holds, clk, rst_n, fin_valid_r && !fin_adv, fin_valid_r && $stable(fin_total_r))

endmodule

>>> hw/rtl/cpp_varint.sv
// One byte step of the variable byte integer decoder (7 bits per byte, LSB first).
// Depends on cpp_pkg.
module cpp_varint import cpp_pkg::*; (
  input  logic [LEN_W-1:0] acc,
  input  logic [IDX_W-1:0] idx,
  input  logic [7:0]       data,
  output cpp_vint_t        step
);

  logic [LEN_W-1:0] placed;

  always_comb begin
    case (idx[1:0])
      2'd0:    placed = {21'b0, data[6:0]};
      2'd1:    placed = {14'b0, data[6:0], 7'b0};
      2'd2:    placed = {7'b0, data[6:0], 14'b0};
      default: placed = {data[6:0], 21'b0};
    endcase
  end

  always_comb begin
    step.acc  = acc | placed;
    step.err  = data[7] && (idx >= VINT_MAX_IDX);
    step.done = !data[7];
    step.idx  = step.err ? idx : idx + IDX_W'(1);
  end

endmodule
